/* sv/wsp_pkg.sv */
// shared types and constants for the wav stream parser
package wsp_pkg;
  localparam int unsigned RateW = 32;
  localparam logic [RateW-1:0] RateReset = 32'd44100;
  localparam int unsigned QDepth = 2;

  localparam logic [1:0] KIND_FRAME  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] ERR_EOS    = 2'd0;
  localparam logic [1:0] ERR_FORMAT = 2'd1;
  localparam logic [1:0] ERR_AUDIO  = 2'd2;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_req_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [29:0]        frame_total;
    logic [1:0]         error_code;
    logic               last_frame;
  } out_req_t;
endpackage

/* sv/wsp_if.sv */
// valid/ready channel interfaces
interface wsp_in_if import wsp_pkg::*; ();
  logic    valid;
  logic    ready;
  in_req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface wsp_out_if import wsp_pkg::*; ();
  logic     valid;
  logic     ready;
  out_req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* sv/wsp_queue.sv */
// short request queue between the front and the back part
module wsp_queue import wsp_pkg::*; #(
  parameter int unsigned Depth = QDepth
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  in_req_t  push_data,
  output logic     full,
  output logic     pop_valid,
  output in_req_t  pop_data,
  input  logic     pop
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  in_req_t mem_r [Depth];
  logic [AW-1:0] wp_r, rp_r, wp_nxt, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == (AW+1)'(Depth));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(Depth-1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == AW'(Depth-1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end
endmodule

/* sv/wsp_back.sv */
// parse engine: runs the chunk walk one byte per cycle unless a result waits unread, and drives the result register
module wsp_back import wsp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [RateW-1:0] rate,
  input  logic             req_valid,
  input  in_req_t          req,
  output logic             req_pop,
  output logic             res_valid,
  output out_req_t         res,
  input  logic             res_ready
);
  localparam logic [2:0] PH_RIFF = 3'd0;
  localparam logic [2:0] PH_CHUNK = 3'd1;
  localparam logic [2:0] PH_FMT = 3'd2;
  localparam logic [2:0] PH_SKIP = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;
  localparam logic [2:0] PH_FAIL = 3'd6;

  logic [2:0]  ph_r, ph_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [7:0]  hb_r [16];
  logic [31:0] riff_r, riff_nxt, chunk_r, chunk_nxt, data_r, data_nxt;
  logic        fmt_seen_r, fmt_seen_nxt;
  logic [7:0]  fb_r [3];
  logic        ov_r, ov_nxt;
  out_req_t    res_r, res_nxt;

  logic        step, emit;
  logic [7:0]  b;
  logic [31:0] w0, w1, w2, w3, size, padded, riff8;
  logic        pad_ovf;

  assign b = req.data_byte;
  // views of the header buffer with the incoming byte in place
  function automatic logic [7:0] hb_at(input logic [3:0] i, input logic [3:0] wi,
                                       input logic [7:0] wb, input logic [7:0] cur);
    hb_at = (i == wi) ? wb : cur;
  endfunction

  always_comb begin
    w0 = {hb_at(4'd3, idx_r, b, hb_r[3]), hb_r[2], hb_r[1], hb_r[0]};
    w1 = {hb_at(4'd7, idx_r, b, hb_r[7]), hb_r[6], hb_r[5], hb_r[4]};
    w2 = {hb_at(4'd11, idx_r, b, hb_r[11]), hb_r[10], hb_r[9], hb_r[8]};
    w3 = {hb_at(4'd15, idx_r, b, hb_r[15]), hb_r[14], hb_r[13], hb_r[12]};
  end

  assign size     = w1;
  assign {pad_ovf, padded} = {1'b0, size} + {32'd0, size[0]};
  assign riff8    = riff_r - 32'd8;

  // one request is taken whenever the result slot is free or being drained
  assign step    = req_valid && (!ov_r || res_ready);
  assign req_pop = step;

  always_comb begin
    ph_nxt       = ph_r;
    idx_nxt      = idx_r;
    riff_nxt     = riff_r;
    chunk_nxt    = chunk_r;
    data_nxt     = data_r;
    fmt_seen_nxt = fmt_seen_r;
    res_nxt      = '0;
    emit         = 1'b0;
    if (step && ph_r != PH_DONE && ph_r != PH_FAIL) begin
      if (req.stream_end) begin
        emit = 1'b1;
        res_nxt.kind = KIND_ERROR;
        res_nxt.error_code = (ph_r == PH_FMT) ? ERR_FORMAT : ERR_EOS;
        ph_nxt = PH_FAIL;
      end else begin
        case (ph_r)
          PH_RIFF: begin
            idx_nxt = idx_r + 4'd1;
            if (idx_r == 4'd11) begin
              idx_nxt = '0;
              if (w0 != TAG_RIFF || w2 != TAG_WAVE || size < 32'd4
                  || size - 32'd4 < 32'd8) begin
                emit = 1'b1;
                res_nxt.kind = KIND_ERROR;
                res_nxt.error_code = ERR_FORMAT;
                ph_nxt = PH_FAIL;
              end else begin
                riff_nxt = size - 32'd4;
                ph_nxt = PH_CHUNK;
              end
            end
          end
          PH_CHUNK: begin
            idx_nxt = idx_r + 4'd1;
            if (idx_r == 4'd7) begin
              idx_nxt = '0;
              riff_nxt = riff8;
              if (pad_ovf || padded > riff8) begin
                emit = 1'b1;
                res_nxt.kind = KIND_ERROR;
                res_nxt.error_code = ERR_FORMAT;
                ph_nxt = PH_FAIL;
              end else if (w0 == TAG_FMT) begin
                if (size < 32'd16) begin
                  emit = 1'b1;
                  res_nxt.kind = KIND_ERROR;
                  res_nxt.error_code = ERR_FORMAT;
                  ph_nxt = PH_FAIL;
                end else begin
                  chunk_nxt = padded - 32'd16;
                  riff_nxt = riff8 - padded;
                  ph_nxt = PH_FMT;
                end
              end else if (w0 == TAG_DATA) begin
                if (!fmt_seen_r || size[1:0] != 2'd0) begin
                  emit = 1'b1;
                  res_nxt.kind = KIND_ERROR;
                  res_nxt.error_code = ERR_FORMAT;
                  ph_nxt = PH_FAIL;
                end else begin
                  emit = 1'b1;
                  data_nxt = size;
                  ph_nxt = (size != '0) ? PH_DATA : PH_DONE;
                  res_nxt.kind = KIND_HEADER;
                  res_nxt.frame_total = size[31:2];
                end
              end else begin
                riff_nxt = riff8 - padded;
                chunk_nxt = padded;
                if (padded == '0) begin
                  if (riff8 < 32'd8) begin
                    emit = 1'b1;
                    res_nxt.kind = KIND_ERROR;
                    res_nxt.error_code = ERR_FORMAT;
                    ph_nxt = PH_FAIL;
                  end
                end else begin
                  ph_nxt = PH_SKIP;
                end
              end
            end
          end
          PH_FMT: begin
            idx_nxt = idx_r + 4'd1;
            if (idx_r == 4'd15) begin
              idx_nxt = '0;
              if (w0 != 32'h0002_0001 || w1 != rate || w2 != {rate[29:0], 2'b00}
                  || w3 != 32'h0010_0004) begin
                emit = 1'b1;
                res_nxt.kind = KIND_ERROR;
                res_nxt.error_code = ERR_AUDIO;
                ph_nxt = PH_FAIL;
              end else begin
                fmt_seen_nxt = 1'b1;
                if (chunk_r != '0) begin
                  ph_nxt = PH_SKIP;
                end else if (riff_r < 32'd8) begin
                  emit = 1'b1;
                  res_nxt.kind = KIND_ERROR;
                  res_nxt.error_code = ERR_FORMAT;
                  ph_nxt = PH_FAIL;
                end else begin
                  ph_nxt = PH_CHUNK;
                end
              end
            end
          end
          PH_SKIP: begin
            chunk_nxt = chunk_r - 32'd1;
            if (chunk_r == 32'd1) begin
              if (riff_r < 32'd8) begin
                emit = 1'b1;
                res_nxt.kind = KIND_ERROR;
                res_nxt.error_code = ERR_FORMAT;
                ph_nxt = PH_FAIL;
              end else begin
                ph_nxt = PH_CHUNK;
              end
            end
          end
          PH_DATA: begin
            if (idx_r < 4'd3) begin
              idx_nxt = idx_r + 4'd1;
            end else begin
              idx_nxt = '0;
              data_nxt = (data_r >= 32'd4) ? data_r - 32'd4 : '0;
              emit = 1'b1;
              res_nxt.kind = KIND_FRAME;
              res_nxt.left_sample = {fb_r[1], fb_r[0]};
              res_nxt.right_sample = {b, fb_r[2]};
              res_nxt.last_frame = (data_nxt == '0);
              if (data_nxt == '0) begin
                ph_nxt = PH_DONE;
              end
            end
          end
          default: begin
            ph_nxt = ph_r;
          end
        endcase
      end
    end
    ov_nxt = emit ? 1'b1 : (res_ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r       <= PH_RIFF;
      idx_r      <= '0;
      riff_r     <= '0;
      chunk_r    <= '0;
      data_r     <= '0;
      fmt_seen_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      ph_r       <= ph_nxt;
      idx_r      <= idx_nxt;
      riff_r     <= riff_nxt;
      chunk_r    <= chunk_nxt;
      data_r     <= data_nxt;
      fmt_seen_r <= fmt_seen_nxt;
      ov_r       <= ov_nxt;
    end
    if (emit) begin
      res_r <= res_nxt;
    end
    if (step && !req.stream_end) begin
      if (ph_r == PH_RIFF || ph_r == PH_CHUNK || ph_r == PH_FMT) begin
        hb_r[idx_r] <= b;
      end
      if (ph_r == PH_DATA && idx_r < 4'd3) begin
        fb_r[idx_r[1:0]] <= b;
      end
    end
  end

  assign res_valid = ov_r;
  assign res       = res_r;
endmodule

/* sv/wav_stream_parser.sv */
// top level of the wav stream parser: front queue feeding the parse engine
// a result is registered in the cycle after the byte that causes it leaves the queue;
// an accepted byte passes through the queue and then the result register
// throughput: one byte per cycle without back-pressure, set by the single-step parse engine
// reset: synchronous active-low rst_n clears queue pointers, parse state and result valid flag
// and sets the rate register to 44100; no clearing pass
module wav_stream_parser import wsp_pkg::*; #(
  parameter int unsigned QueueDepth = QDepth
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [RateW-1:0] cfg_wdata,
  wsp_in_if.sink           in_ch,
  wsp_out_if.source        out_ch
);
  logic [RateW-1:0] rate_r;
  logic    q_full, q_valid, q_pop;
  in_req_t q_data;

  // configuration register; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RateReset;
    end else if (cfg_we) begin
      rate_r <= cfg_wdata;
    end
  end

  // front: accept requests into the queue whenever there is room
  assign in_ch.ready = !q_full;

  wsp_queue #(.Depth(QueueDepth)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_ch.valid && !q_full),
    .push_data (in_ch.payload),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_data  (q_data),
    .pop       (q_pop)
  );

  // back: parse engine with its own output register
  wsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rate      (rate_r),
    .req_valid (q_valid),
    .req       (q_data),
    .req_pop   (q_pop),
    .res_valid (out_ch.valid),
    .res       (out_ch.payload),
    .res_ready (out_ch.ready)
  );
endmodule

/* sv/wsp_checker.sv */
// port-level checker for the wav stream parser and its bind
module wsp_props import wsp_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input out_req_t out_payload
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload)) else $error("out hold");
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_payload.kind == KIND_FRAME || out_payload.kind == KIND_HEADER
      || out_payload.kind == KIND_ERROR) else $error("bad kind");
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.kind == KIND_ERROR |-> out_payload.last_frame == 1'b0
      && out_payload.frame_total == '0) else $error("error fields");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("valid after reset");
endmodule

bind wav_stream_parser wsp_props u_wsp_props (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_payload (out_ch.payload)
);

/* tb/wsp_checker.sv */
// checker for the wav stream parser: predicts every result and compares
module wsp_checker import wsp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [RateW-1:0] cfg_wdata,
  wsp_in_if                in_ch,
  wsp_out_if               out_ch,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    P_RIFF, P_CHUNK, P_FMT, P_SKIP, P_DATA, P_DONE, P_FAIL
  } phase_t;

  logic [31:0] rate;
  phase_t      phase;
  int          idx;
  logic [7:0]  hb [16];
  logic [31:0] riff_left, chunk_left, data_left;
  logic        fmt_ok, failed;
  logic [7:0]  fb [3];
  out_req_t    frames_q [$];

  function automatic logic [31:0] le32(input int at);
    return {hb[at+3], hb[at+2], hb[at+1], hb[at]};
  endfunction

  function automatic logic [15:0] le16(input int at);
    return {hb[at+1], hb[at]};
  endfunction

  function automatic bit raise(input logic [1:0] code, inout out_req_t r);
    failed = 1'b1;
    phase = P_FAIL;
    r.kind = KIND_ERROR;
    r.error_code = code;
    return 1'b1;
  endfunction

  function automatic bit next_chunk(inout out_req_t r);
    idx = 0;
    if (riff_left >= 32'd8) begin
      phase = P_CHUNK;
      return 1'b0;
    end
    return raise(ERR_FORMAT, r);
  endfunction

  function automatic bit parse_byte(input in_req_t q, output out_req_t r);
    logic [31:0] size, padded, brate;
    logic [7:0]  b;
    b = q.data_byte;
    r = '0;
    if (failed || phase == P_FAIL || phase == P_DONE) return 1'b0;
    if (q.stream_end) return raise(phase == P_FMT ? ERR_FORMAT : ERR_EOS, r);
    case (phase)
      P_RIFF: begin
        hb[idx] = b;
        idx++;
        if (idx < 12) return 1'b0;
        idx = 0;
        size = le32(4);
        if (le32(0) != TAG_RIFF || le32(8) != TAG_WAVE || size < 32'd4)
          return raise(ERR_FORMAT, r);
        riff_left = size - 32'd4;
        return next_chunk(r);
      end
      P_CHUNK: begin
        hb[idx] = b;
        idx++;
        if (idx < 8) return 1'b0;
        idx = 0;
        riff_left = riff_left - 32'd8;
        size = le32(4);
        padded = size + {31'd0, size[0]};
        if (padded < size || padded > riff_left) return raise(ERR_FORMAT, r);
        if (le32(0) == TAG_FMT) begin
          if (size < 32'd16) return raise(ERR_FORMAT, r);
          chunk_left = padded - 32'd16;
          riff_left = riff_left - padded;
          phase = P_FMT;
          return 1'b0;
        end
        if (le32(0) == TAG_DATA) begin
          if (!fmt_ok || size[1:0] != 2'd0) return raise(ERR_FORMAT, r);
          data_left = size;
          phase = (size != 0) ? P_DATA : P_DONE;
          r.kind = KIND_HEADER;
          r.frame_total = size[31:2];
          return 1'b1;
        end
        riff_left = riff_left - padded;
        chunk_left = padded;
        if (padded == 0) return next_chunk(r);
        phase = P_SKIP;
        return 1'b0;
      end
      P_FMT: begin
        hb[idx] = b;
        idx++;
        if (idx < 16) return 1'b0;
        idx = 0;
        brate = rate * 32'd4;
        if (le16(0) != 16'd1 || le16(2) != 16'd2 || le32(4) != rate
            || le32(8) != brate || le16(12) != 16'd4 || le16(14) != 16'd16)
          return raise(ERR_AUDIO, r);
        fmt_ok = 1'b1;
        if (chunk_left == 0) return next_chunk(r);
        phase = P_SKIP;
        return 1'b0;
      end
      P_SKIP: begin
        chunk_left = chunk_left - 32'd1;
        if (chunk_left == 0) return next_chunk(r);
        return 1'b0;
      end
      P_DATA: begin
        if (idx < 3) begin
          fb[idx] = b;
          idx++;
          return 1'b0;
        end
        idx = 0;
        data_left = (data_left >= 32'd4) ? data_left - 32'd4 : 32'd0;
        r.kind = KIND_FRAME;
        r.left_sample = {fb[1], fb[0]};
        r.right_sample = {b, fb[2]};
        r.last_frame = (data_left == 0);
        if (data_left == 0) phase = P_DONE;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
    $display("mismatch on %s: expected %0h, got %0h", field, want, got);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    out_req_t want, got, r;
    if (!rst_n) begin
      rate = RateReset;
      phase = P_RIFF;
      idx = 0;
      riff_left = '0;
      chunk_left = '0;
      data_left = '0;
      fmt_ok = 1'b0;
      failed = 1'b0;
      frames_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        if (frames_q.size() == 0) begin
          report("unexpected result kind", 32'd0, {30'd0, got.kind});
        end else begin
          want = frames_q.pop_front();
          if (got.kind !== want.kind) report("kind", 32'(want.kind), 32'(got.kind));
          if (got.left_sample !== want.left_sample)
            report("left_sample", 32'(want.left_sample), 32'(got.left_sample));
          if (got.right_sample !== want.right_sample)
            report("right_sample", 32'(want.right_sample), 32'(got.right_sample));
          if (got.frame_total !== want.frame_total)
            report("frame_total", 32'(want.frame_total), 32'(got.frame_total));
          if (got.error_code !== want.error_code)
            report("error_code", 32'(want.error_code), 32'(got.error_code));
          if (got.last_frame !== want.last_frame)
            report("last_frame", 32'(want.last_frame), 32'(got.last_frame));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (parse_byte(in_ch.payload, r)) frames_q.push_back(r);
      end
      if (cfg_we) rate = cfg_wdata;
    end
    pending <= frames_q.size();
  end
endmodule

/* tb/tb_wav_stream_parser.sv */
// top of the wav stream parser testbench: stimulus, clock, reset and verdict
module tb_wav_stream_parser;
  import wsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [RateW-1:0] cfg_wdata;
  int               fail_count;
  int               pending;
  int               cyc = 0;
  int               sent = 0;
  int               tx_pct, rx_pct;
  in_req_t          stream [$];

  wsp_in_if  in_ch ();
  wsp_out_if out_ch ();

  wav_stream_parser DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  wsp_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog, far beyond the slowest legal run
  always @(posedge clk) begin
    cyc++;
    if (cyc > 200000) begin
      $display("[wav_stream_parser] ERROR");
      $finish;
    end
  end

  // receiver back-pressure, one draw per cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rx_pct);
    end
  end

  // stream building helpers
  task automatic add_byte(input logic [7:0] b);
    in_req_t q;
    q.data_byte = b;
    q.stream_end = 1'b0;
    stream.push_back(q);
  endtask

  task automatic add_u16(input logic [15:0] v);
    add_byte(v[7:0]);
    add_byte(v[15:8]);
  endtask

  task automatic add_u32(input logic [31:0] v);
    add_u16(v[15:0]);
    add_u16(v[31:16]);
  endtask

  task automatic add_end(input logic [7:0] b);
    in_req_t q;
    q.data_byte = b;
    q.stream_end = 1'b1;
    stream.push_back(q);
  endtask

  // fmt chunk of given size for 16-bit stereo pcm at rate r, extra bytes random
  task automatic add_fmt(input logic [31:0] size, input logic [31:0] r);
    int extra;
    add_u32(TAG_FMT);
    add_u32(size);
    add_u16(16'd1);
    add_u16(16'd2);
    add_u32(r);
    add_u32(r * 32'd4);
    add_u16(16'd4);
    add_u16(16'd16);
    extra = size - 16 + size[0];
    repeat (extra) add_byte($urandom_range(0, 255));
  endtask

  // unknown chunk with a random tag, odd sizes get a pad byte
  task automatic add_junk(input logic [31:0] size);
    logic [31:0] tag;
    tag = $urandom;
    if (tag == TAG_FMT || tag == TAG_DATA || tag == TAG_RIFF) tag = tag ^ 32'h1;
    add_u32(tag);
    add_u32(size);
    repeat (size + size[0]) add_byte($urandom_range(0, 255));
  endtask

  // idle levels follow how far the run has got
  task automatic set_idle();
    if (sent < 300) begin
      tx_pct = 15;
      rx_pct = 75;
    end else if (sent < 600) begin
      tx_pct = 75;
      rx_pct = 15;
    end else begin
      tx_pct = 0;
      rx_pct = 0;
    end
  endtask

  // push the built stream through the input channel, one request per handshake
  task automatic send_stream();
    in_req_t q;
    while (stream.size() != 0) begin
      q = stream.pop_front();
      set_idle();
      while ($urandom_range(0, 99) < tx_pct) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
      in_ch.valid <= 1'b1;
      in_ch.payload <= q;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      sent++;
      // hold off once mid-data until the results have all drained
      if (sent == 450) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  // let the block go quiet, then change the rate
  task automatic write_rate(input logic [31:0] v);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [31:0] r;
    int          nfr, cut;
    bit          early_end;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    tx_pct = 15;
    rx_pct = 75;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // riff header with the largest body size, then empty and odd unknown chunks
    add_u32(TAG_RIFF);
    add_u32(32'hFFFF_FFFF);
    add_u32(TAG_WAVE);
    add_junk(32'd0);
    add_junk(32'd3);
    send_stream();

    // rate at both extremes, each checked by a fmt chunk
    write_rate(32'd0);
    add_fmt(32'd16, 32'd0);
    send_stream();
    write_rate(32'hFFFF_FFFF);
    add_fmt(32'd17, 32'hFFFF_FFFF);
    send_stream();
    r = $urandom;
    write_rate(r);
    add_fmt(32'd20, r);
    repeat ($urandom_range(2, 6)) add_junk($urandom_range(0, 40));
    send_stream();

    // back to the default rate, then the data chunk
    write_rate(RateReset);
    add_fmt(32'd16 + $urandom_range(0, 5), RateReset);
    nfr = $urandom_range(140, 160);
    add_u32(TAG_DATA);
    add_u32(nfr * 4);
    // sample extremes first
    add_u16(16'h0000);
    add_u16(16'h8000);
    add_u16(16'h7FFF);
    add_u16(16'hFFFF);
    repeat (nfr * 4 - 8) add_byte($urandom_range(0, 255));
    early_end = $urandom_range(0, 1);
    if (early_end) begin
      // premature end late in the data: partial frame dropped
      cut = (nfr * 4 - $urandom_range(6, 60)) | 1;
      while (stream.size() > cut + 8 + 16) void'(stream.pop_back());
      add_end($urandom_range(0, 255));
    end else begin
      // after the last frame further bytes and the end mark are ignored
      repeat (5) add_byte($urandom_range(0, 255));
      add_end($urandom_range(0, 255));
    end
    send_stream();

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[wav_stream_parser] OK");
    end else begin
      $display("[wav_stream_parser] ERROR");
    end
    $finish;
  end
endmodule
